/* hw/rtl/bpcr_pkg.sv */
package bpcr_pkg;

  localparam int DEF_FRACTION_BITS = 8;

  localparam int POS_W  = 20;
  localparam int SIZE_W = 19;
  localparam int VEL_W  = 16;
  localparam int IM_W   = 12;
  localparam int REST_W = 9;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_FIRST_IM  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SECOND_IM = 2'd1;
  localparam logic [IDX_W-1:0] CFG_REST      = 2'd2;

  localparam logic [IM_W-1:0]   IM_RESET   = 12'd256;
  localparam logic [REST_W-1:0] REST_RESET = 9'd243;
  localparam logic [REST_W-1:0] REST_ONE   = 9'd256;

  // contact normal codes
  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_NX = 2'd1;
  localparam logic [1:0] DIR_PY = 2'd2;
  localparam logic [1:0] DIR_NY = 2'd3;

  // quotient bits of the divide units, velocity and correction deltas stay below 2^17
  localparam int QUO_W  = 18;
  localparam int VNUM_W = 40;
  localparam int VDEN_W = 21;
  localparam int CNUM_W = 32;
  localparam int CDEN_W = 16;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic        [SIZE_W-1:0] w;
    logic        [SIZE_W-1:0] h;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } body_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } kin_t;

  typedef struct packed {
    logic              contact;
    logic [1:0]        dir;
    logic              ax;
    logic              neg;
    logic [SIZE_W-1:0] pen;
    logic              do_res;
  } ctl_t;

  typedef struct packed {
    kin_t a;
    kin_t b;
    ctl_t ctl;
  } side_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [19:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[VEL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [21:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 22'sd524287) r = 20'sh7ffff;
    else if (v < -22'sd524288) r = 20'sh80000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

/* hw/rtl/bpcr_div_pipe.sv */
module bpcr_div_pipe
  import bpcr_pkg::*;
#(
  parameter int NW = 40,
  parameter int DW = 21,
  parameter int QW = 18
) (
  input  logic          clk_i,
  input  logic [QW-1:0] en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  // restoring divide, one quotient bit per stage, msb first
  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [NW-1:0] rin   [QW];
  logic [QW-1:0] qin   [QW];
  logic [NW-1:0] den_ext;

  assign den_ext = NW'(den_i);

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic ge;
    if (j == 0) begin : g_first
      assign rin[j] = num_i;
      assign qin[j] = '0;
    end else begin : g_next
      assign rin[j] = rem_q[j-1];
      assign qin[j] = quo_q[j-1];
    end
    assign ge = (rin[j] >> K) >= den_ext;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= ge ? rin[j] - (den_ext << K) : rin[j];
        quo_q[j] <= qin[j] | (QW'(ge) << K);
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* hw/rtl/box_pair_collision_response.sv */
// Box pair collision response.
// Input channel: in_valid_i / in_stall_o carry one box pair per word: corner,
// size and velocity of each body. A word is taken on a clock edge with
// in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry the contact flags, depth and
// the corrected positions and velocities, one result word per input word.
// The word passes QUO_W + 5 register stages from acceptance to out_valid_o:
// input register, overlap test, two multiply stages, one stage per quotient
// bit of the divide units, output register.
// Throughput: one word per cycle while out_stall_i is low; every stage holds
// its own valid bit, so bubbles are squeezed out when the receiver stalls
// and no word is lost.
// The user writes the inverse-mass and restitution registers through cfg_we_i,
// cfg_idx_i and cfg_data_i only while no word is in flight; the block does not enforce this.
// Reset clears all stage valid bits and loads inverse masses of 1.0 and a
// restitution of 243/256.
module box_pair_collision_response
  import bpcr_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [POS_W-1:0]  first_x_i,
  input  logic signed [POS_W-1:0]  first_y_i,
  input  logic [SIZE_W-1:0]        first_width_i,
  input  logic [SIZE_W-1:0]        first_height_i,
  input  logic signed [VEL_W-1:0]  first_vx_i,
  input  logic signed [VEL_W-1:0]  first_vy_i,
  input  logic signed [POS_W-1:0]  second_x_i,
  input  logic signed [POS_W-1:0]  second_y_i,
  input  logic [SIZE_W-1:0]        second_width_i,
  input  logic [SIZE_W-1:0]        second_height_i,
  input  logic signed [VEL_W-1:0]  second_vx_i,
  input  logic signed [VEL_W-1:0]  second_vy_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     contact_o,
  output logic [1:0]               normal_dir_o,
  output logic [SIZE_W-1:0]        penetration_depth_o,
  output logic                     resolved_o,
  output logic signed [POS_W-1:0]  new_first_x_o,
  output logic signed [POS_W-1:0]  new_first_y_o,
  output logic signed [POS_W-1:0]  new_second_x_o,
  output logic signed [POS_W-1:0]  new_second_y_o,
  output logic signed [VEL_W-1:0]  new_first_vx_o,
  output logic signed [VEL_W-1:0]  new_first_vy_o,
  output logic signed [VEL_W-1:0]  new_second_vx_o,
  output logic signed [VEL_W-1:0]  new_second_vy_o
);

  localparam int NS = QUO_W + 5;
  localparam int DS = 4;
  localparam logic [SIZE_W-1:0] SLOP = SIZE_W'(((1 << FRACTION_BITS) + 50) / 100);

  // configuration
  logic [IM_W-1:0]   ima_q, imb_q;
  logic [REST_W-1:0] rest_q;
  logic [IM_W:0]     sum;
  logic [REST_W-1:0] e_eff;
  logic [VDEN_W-1:0] den_v;
  logic [CDEN_W-1:0] den_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ima_q  <= IM_RESET;
      imb_q  <= IM_RESET;
      rest_q <= REST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_IM:  ima_q  <= cfg_data_i;
        CFG_SECOND_IM: imb_q  <= cfg_data_i;
        CFG_REST:      rest_q <= cfg_data_i[REST_W-1:0];
        default: ;
      endcase
    end
  end

  assign sum   = {1'b0, ima_q} + {1'b0, imb_q};
  assign e_eff = (rest_q > REST_ONE) ? REST_ONE : rest_q;
  assign den_v = {sum, 8'd0};
  assign den_c = {1'b0, sum, 2'b00} + CDEN_W'(sum);

  // stage handshake
  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage 0: input register
  body_t s0a_q, s0b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0a_q <= '{x: first_x_i, y: first_y_i, w: first_width_i, h: first_height_i,
                 vx: first_vx_i, vy: first_vy_i};
      s0b_q <= '{x: second_x_i, y: second_y_i, w: second_width_i, h: second_height_i,
                 vx: second_vx_i, vy: second_vy_i};
    end
  end

  // stage 1: overlap test, axis and normal
  logic signed [21:0] c0x, c0y, c1x, c1y;
  logic signed [22:0] dx, dy, dsel;
  logic [22:0]        adx, ady;
  logic signed [23:0] ovx, ovy, ovsel;
  logic               s1_contact, s1_ax, s1_neg, s1_le0;
  logic signed [16:0] rel, vn, nvn;
  ctl_t               s1_ctl;

  always_comb begin
    c0x = {s0a_q.x[POS_W-1], s0a_q.x, 1'b0} + {3'b0, s0a_q.w};
    c0y = {s0a_q.y[POS_W-1], s0a_q.y, 1'b0} + {3'b0, s0a_q.h};
    c1x = {s0b_q.x[POS_W-1], s0b_q.x, 1'b0} + {3'b0, s0b_q.w};
    c1y = {s0b_q.y[POS_W-1], s0b_q.y, 1'b0} + {3'b0, s0b_q.h};
    dx  = {c1x[21], c1x} - {c0x[21], c0x};
    dy  = {c1y[21], c1y} - {c0y[21], c0y};
    adx = dx[22] ? 23'(-dx) : 23'(dx);
    ady = dy[22] ? 23'(-dy) : 23'(dy);
    ovx = {5'b0, s0a_q.w} + {5'b0, s0b_q.w} - {1'b0, adx};
    ovy = {5'b0, s0a_q.h} + {5'b0, s0b_q.h} - {1'b0, ady};
    s1_contact = !ovx[23] && (ovx != '0) && !ovy[23] && (ovy != '0);
    s1_ax = !(ovx < ovy);   // ties go to y
    dsel  = s1_ax ? dy : dx;
    ovsel = s1_ax ? ovy : ovx;
    s1_neg = dsel[22];
    rel = s1_ax ? ({s0b_q.vy[VEL_W-1], s0b_q.vy} - {s0a_q.vy[VEL_W-1], s0a_q.vy})
                : ({s0b_q.vx[VEL_W-1], s0b_q.vx} - {s0a_q.vx[VEL_W-1], s0a_q.vx});
    vn  = s1_neg ? -rel : rel;
    nvn = -vn;
    s1_le0 = vn[16] || (vn == '0);

    s1_ctl.contact = s1_contact;
    s1_ctl.ax      = s1_contact && s1_ax;
    s1_ctl.neg     = s1_contact && s1_neg;
    s1_ctl.dir     = !s1_contact ? DIR_PX :
                     s1_ax ? (s1_neg ? DIR_NY : DIR_PY) : (s1_neg ? DIR_NX : DIR_PX);
    s1_ctl.pen     = s1_contact ? ovsel[SIZE_W:1] : '0;
    s1_ctl.do_res  = s1_contact && s1_le0 && (sum != '0);
  end

  kin_t               s1a_q, s1b_q;
  ctl_t               s1_ctl_q;
  logic [VEL_W-1:0]   s1_mag_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1a_q    <= '{x: s0a_q.x, y: s0a_q.y, vx: s0a_q.vx, vy: s0a_q.vy};
      s1b_q    <= '{x: s0b_q.x, y: s0b_q.y, vx: s0b_q.vx, vy: s0b_q.vy};
      s1_ctl_q <= s1_ctl;
      s1_mag_q <= nvn[VEL_W-1:0];
    end
  end

  // stage 2: restitution product and correction products
  logic [SIZE_W-1:0] p;
  logic [9:0]        ef;

  assign p  = (s1_ctl_q.pen > SLOP) ? s1_ctl_q.pen - SLOP : '0;
  assign ef = 10'd256 + {1'b0, e_eff};

  kin_t        s2a_q, s2b_q;
  ctl_t        s2_ctl_q;
  logic [25:0] s2_m1_q;
  logic [30:0] s2_pima_q, s2_pimb_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2a_q     <= s1a_q;
      s2b_q     <= s1b_q;
      s2_ctl_q  <= s1_ctl_q;
      s2_m1_q   <= 26'(ef) * 26'(s1_mag_q);
      s2_pima_q <= 31'(p) * 31'(ima_q);
      s2_pimb_q <= 31'(p) * 31'(imb_q);
    end
  end

  // stage 3: mass products, rounding offsets added
  side_t              s3_side_q;
  logic [VNUM_W-1:0]  s3_na_q, s3_nb_q;
  logic [CNUM_W-1:0]  s3_nca_q, s3_ncb_q;
  logic [VNUM_W-1:0]  vhalf;
  logic [CNUM_W-1:0]  chalf;

  assign vhalf = VNUM_W'(sum) << 7;
  assign chalf = CNUM_W'(den_c >> 1);

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_side_q <= '{a: s2a_q, b: s2b_q, ctl: s2_ctl_q};
      s3_na_q   <= VNUM_W'(s2_m1_q) * VNUM_W'(ima_q) + vhalf;
      s3_nb_q   <= VNUM_W'(s2_m1_q) * VNUM_W'(imb_q) + vhalf;
      s3_nca_q  <= CNUM_W'(s2_pima_q) + chalf;
      s3_ncb_q  <= CNUM_W'(s2_pimb_q) + chalf;
    end
  end

  // divide stages
  logic [QUO_W-1:0] da, db, ca, cb;

  bpcr_div_pipe #(.NW(VNUM_W), .DW(VDEN_W), .QW(QUO_W)) u_div_da (
    .clk_i, .en_i(rdy[DS +: QUO_W]), .num_i(s3_na_q), .den_i(den_v), .quo_o(da)
  );
  bpcr_div_pipe #(.NW(VNUM_W), .DW(VDEN_W), .QW(QUO_W)) u_div_db (
    .clk_i, .en_i(rdy[DS +: QUO_W]), .num_i(s3_nb_q), .den_i(den_v), .quo_o(db)
  );
  bpcr_div_pipe #(.NW(CNUM_W), .DW(CDEN_W), .QW(QUO_W)) u_div_ca (
    .clk_i, .en_i(rdy[DS +: QUO_W]), .num_i(s3_nca_q), .den_i(den_c), .quo_o(ca)
  );
  bpcr_div_pipe #(.NW(CNUM_W), .DW(CDEN_W), .QW(QUO_W)) u_div_cb (
    .clk_i, .en_i(rdy[DS +: QUO_W]), .num_i(s3_ncb_q), .den_i(den_c), .quo_o(cb)
  );

  side_t side_q [QUO_W];

  always_ff @(posedge clk_i) begin
    if (rdy[DS]) side_q[0] <= s3_side_q;
    for (int j = 1; j < QUO_W; j++) begin
      if (rdy[DS+j]) side_q[j] <= side_q[j-1];
    end
  end

  // final stage: apply deltas along the normal, saturate
  side_t              sf;
  logic signed [19:0] va, vb, dva, dvb;
  logic signed [21:0] pa, pb, dpa, dpb;
  logic signed [VEL_W-1:0] nva, nvb;
  logic signed [POS_W-1:0] npa, npb;

  always_comb begin
    sf  = side_q[QUO_W-1];
    va  = sf.ctl.ax ? 20'(sf.a.vy) : 20'(sf.a.vx);
    vb  = sf.ctl.ax ? 20'(sf.b.vy) : 20'(sf.b.vx);
    pa  = sf.ctl.ax ? 22'(sf.a.y) : 22'(sf.a.x);
    pb  = sf.ctl.ax ? 22'(sf.b.y) : 22'(sf.b.x);
    dva = {2'b0, da};
    dvb = {2'b0, db};
    dpa = {4'b0, ca};
    dpb = {4'b0, cb};
    nva = sat_vel(sf.ctl.neg ? va + dva : va - dva);
    nvb = sat_vel(sf.ctl.neg ? vb - dvb : vb + dvb);
    npa = sat_pos(sf.ctl.neg ? pa + dpa : pa - dpa);
    npb = sat_pos(sf.ctl.neg ? pb - dpb : pb + dpb);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      contact_o           <= sf.ctl.contact;
      normal_dir_o        <= sf.ctl.dir;
      penetration_depth_o <= sf.ctl.pen;
      resolved_o          <= sf.ctl.do_res;
      new_first_x_o       <= sf.a.x;
      new_first_y_o       <= sf.a.y;
      new_second_x_o      <= sf.b.x;
      new_second_y_o      <= sf.b.y;
      new_first_vx_o      <= sf.a.vx;
      new_first_vy_o      <= sf.a.vy;
      new_second_vx_o     <= sf.b.vx;
      new_second_vy_o     <= sf.b.vy;
      if (sf.ctl.do_res) begin
        if (sf.ctl.ax) begin
          new_first_y_o   <= npa;
          new_second_y_o  <= npb;
          new_first_vy_o  <= nva;
          new_second_vy_o <= nvb;
        end else begin
          new_first_x_o   <= npa;
          new_second_x_o  <= npb;
          new_first_vx_o  <= nva;
          new_second_vx_o <= nvb;
        end
      end
    end
  end

endmodule
